@@ design/vrot_pkg.sv @@
// ----------------------------------------------------------------------------
// vrot_pkg: shared types and constants for the vector rotation unit
// Widths, fold limits, the arctangent table and the gain constant.
// ----------------------------------------------------------------------------
package vrot_pkg;

  localparam int Iterations = 16;
  localparam int DataWidth  = 16;
  localparam int AngleWidth = 16;

  // Internal widths: x/y grow by the CORDIC gain after folding, z keeps a sign.
  localparam int XW      = DataWidth + 3;
  localparam int ZW      = AngleWidth + 1;
  localparam int OutW    = DataWidth + 1;
  localparam int ShiftW  = $clog2(Iterations);
  localparam int GainShift = 15;
  localparam int ProdW   = XW + GainShift + 1;

  localparam int InTdataW  = ((2 * DataWidth + AngleWidth + 7) / 8) * 8;
  localparam int OutTdataW = ((2 * OutW + 7) / 8) * 8;

  localparam logic [GainShift-1:0] GainComp = GainShift'(19898);

  localparam logic signed [ZW-1:0] ZHalf     = ZW'(1) << (AngleWidth - 1);
  localparam logic signed [ZW-1:0] ZQuarter  = ZW'(1) << (AngleWidth - 2);
  localparam logic signed [ZW-1:0] ZQuarterN = -ZQuarter;

  // atan(2^-i) in units of 2^-32 turn
  localparam int AtanEntries = 24;
  localparam logic [31:0] AtanTurn32 [AtanEntries] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Micro-rotation state carried down the pipeline
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vrot_vec_t;

  // Table entry rescaled to angle units, rounded half up
  function automatic logic [AngleWidth-1:0] vrot_atan(input int idx);
    logic [32:0] t;
    t = '0;
    if (idx >= AtanEntries) begin
      return '0;
    end
    t = {1'b0, AtanTurn32[idx]};
    if (AngleWidth >= 32) begin
      return AngleWidth'(t);
    end
    t = (t + (33'd1 << (31 - AngleWidth))) >> (32 - AngleWidth);
    return AngleWidth'(t);
  endfunction

endpackage

@@ design/vrot_micro.sv @@
// ----------------------------------------------------------------------------
// vrot_micro: one CORDIC micro-rotation
// Shift-and-add step driving the residual angle toward zero.
// ----------------------------------------------------------------------------
module vrot_micro import vrot_pkg::*; (
  input  vrot_vec_t               vec_i,
  input  logic [ShiftW-1:0]       shift_i,
  input  logic [AngleWidth-1:0]   atan_i,
  output vrot_vec_t               vec_o
);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] step;

  // floor shifts
  assign dx   = vec_i.y >>> shift_i;
  assign dy   = vec_i.x >>> shift_i;
  assign step = signed'({1'b0, atan_i});

  always_comb begin
    if (!vec_i.z[ZW-1]) begin
      vec_o.x = vec_i.x - dx;
      vec_o.y = vec_i.y + dy;
      vec_o.z = vec_i.z - step;
    end else begin
      vec_o.x = vec_i.x + dx;
      vec_o.y = vec_i.y - dy;
      vec_o.z = vec_i.z + step;
    end
  end

endmodule

@@ design/vector_rotate_by_angle_unit.sv @@
// ----------------------------------------------------------------------------
// vector_rotate_by_angle_unit: pipelined CORDIC vector rotation
// Rotates (x, y) counterclockwise by a turn-fraction angle, gain compensated.
// ----------------------------------------------------------------------------
// Pipeline: the fold register loads at the transfer edge, then one stage per
//   micro-rotation, then the gain-multiply output register.
// Throughput: one transfer per cycle while the output is not stalled; every stage is one register deep.
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module vector_rotate_by_angle_unit import vrot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // slave side
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InTdataW-1:0]  s_axis_tdata,   // x_in, y_in, angle (from bit 0)
  // master side
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata    // x_out, y_out, zero pad
);

  localparam int NStg = Iterations + 1;
  localparam logic signed [ProdW-1:0] GainS = ProdW'(GainComp);

  // Global advance: the whole pipe moves when the output slot is free
  // or being taken this cycle. A stall freezes every stage in place.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // --------------------------------------------------------------------------
  // Quadrant fold: angle as signed turn fraction, bring into -90..+90 deg
  // by negating the point and moving half a turn. Exactly +/-90 stays put.
  // --------------------------------------------------------------------------
  logic signed [DataWidth-1:0]  x_in;
  logic signed [DataWidth-1:0]  y_in;
  logic signed [AngleWidth-1:0] ang_in;
  vrot_vec_t                    fold_d;

  assign x_in   = s_axis_tdata[DataWidth-1:0];
  assign y_in   = s_axis_tdata[2*DataWidth-1:DataWidth];
  assign ang_in = s_axis_tdata[2*DataWidth+AngleWidth-1:2*DataWidth];

  always_comb begin
    fold_d.x = XW'(x_in);
    fold_d.y = XW'(y_in);
    fold_d.z = ZW'(ang_in);
    if (fold_d.z > ZQuarter) begin
      fold_d.z = fold_d.z - ZHalf;
      fold_d.x = -fold_d.x;
      fold_d.y = -fold_d.y;
    end else if (fold_d.z < ZQuarterN) begin
      fold_d.z = fold_d.z + ZHalf;
      fold_d.x = -fold_d.x;
      fold_d.y = -fold_d.y;
    end
  end

  // --------------------------------------------------------------------------
  // Stage registers: stg_q[0] holds the folded point, stg_q[k+1] the result
  // of micro-rotation k. vld_q[NStg] marks the output register.
  // --------------------------------------------------------------------------
  vrot_vec_t  stg_q [NStg];
  vrot_vec_t  stg_d [NStg];
  logic [NStg:0] vld_q;

  assign stg_d[0] = fold_d;

  for (genvar k = 0; k < Iterations; k++) begin : g_iter
    localparam logic [ShiftW-1:0]     StepIdx  = ShiftW'(k);
    localparam logic [AngleWidth-1:0] StepAtan = vrot_atan(k);

    vrot_micro u_micro (
      .vec_i   (stg_q[k]),
      .shift_i (StepIdx),
      .atan_i  (StepAtan),
      .vec_o   (stg_d[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-1:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NStg; k++) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gain compensation: multiply by 0.60724 in Q1.15, product registered in
  // the output slot; the floor shift by 15 is a plain bit select.
  // --------------------------------------------------------------------------
  logic signed [ProdW-1:0] x_prod_d;
  logic signed [ProdW-1:0] y_prod_d;
  logic signed [ProdW-1:0] x_prod_q;
  logic signed [ProdW-1:0] y_prod_q;

  assign x_prod_d = ProdW'(stg_q[Iterations].x) * GainS;
  assign y_prod_d = ProdW'(stg_q[Iterations].y) * GainS;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_prod_q <= x_prod_d;
      y_prod_q <= y_prod_d;
    end
  end

  assign m_axis_tvalid = vld_q[NStg];
  assign m_axis_tdata  = {
    (OutTdataW - 2 * OutW)'(0),
    y_prod_q[GainShift +: OutW],
    x_prod_q[GainShift +: OutW]
  };

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted transfer did not enter the fold stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_fold_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (stg_q[0].z <= ZQuarter && stg_q[0].z >= ZQuarterN))
    else $error("folded angle outside a quarter turn");

  a_out_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && $rose(m_axis_tvalid)) |-> $past(vld_q[NStg-1]))
    else $error("output valid without an item in the last stage");

endmodule

@@ bench/vector_rotate_by_angle_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_rotate_by_angle_unit_tb: stream-level test of the CORDIC rotator
// A bit-exact fixed-point predictor runs on every input transfer. Each output
// transfer is checked in order against it while both stream sides idle and
// stall at random. The run covers directed corners, random points, a long
// output hold-off that backs up the pipe, and bursts that drain fully.
// ----------------------------------------------------------------------------
module vector_rotate_by_angle_unit_tb;
  import vrot_pkg::*;

  // Fold limits in angle units
  localparam longint AngFull    = longint'(1) << AngleWidth;
  localparam longint AngHalf    = AngFull >> 1;
  localparam longint AngQuarter = AngFull >> 2;

  // Gain compensation, Q1.15
  localparam longint GainQ15   = 19898;
  localparam int     GainFrac  = 15;
  localparam int     PipeDepth = Iterations + 2;

  // atan(2^-i) as a fraction of a turn, scaled by 2^32
  localparam int TurnAtanCount = 24;
  localparam logic [31:0] TurnAtanQ32 [TurnAtanCount] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
  } point_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;  // x_in, y_in, angle (from bit 0)
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;        // x_out, y_out, zero pad

  // Rotated points still owed by the block, oldest first
  point_t expected_rotations[$];
  int     mismatch_count = 0;

  // Idle controls shared by the sender and the receiver
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  bit hold_req     = 1'b0;
  int hold_cycles  = 0;

  vector_rotate_by_angle_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: fold into +-90 degrees, micro-rotate, remove the gain.
  // longint >>> floors, matching the floor shifts of the datapath.
  // --------------------------------------------------------------------------
  function automatic point_t rotate_point(input logic [DataWidth-1:0]  x_raw,
                                          input logic [DataWidth-1:0]  y_raw,
                                          input logic [AngleWidth-1:0] ang);
    longint px, py, resid, dx, dy, step;
    point_t res;
    px    = longint'($signed(x_raw));
    py    = longint'($signed(y_raw));
    resid = longint'(ang);
    if (resid >= AngHalf) resid -= AngFull;
    // exactly +-quarter stays unfolded; exactly half folds to zero
    if (resid > AngQuarter) begin
      resid -= AngHalf;
      px = -px;
      py = -py;
    end else if (resid < -AngQuarter) begin
      resid += AngHalf;
      px = -px;
      py = -py;
    end
    for (int i = 0; i < Iterations; i++) begin
      dx = py >>> i;
      dy = px >>> i;
      if (i >= TurnAtanCount) begin
        step = 0;
      end else if (AngleWidth >= 32) begin
        step = longint'(TurnAtanQ32[i]);
      end else begin
        // round half up into angle units
        step = (longint'(TurnAtanQ32[i]) + (longint'(1) << (31 - AngleWidth)))
               >> (32 - AngleWidth);
      end
      if (resid >= 0) begin
        px    -= dx;
        py    += dy;
        resid -= step;
      end else begin
        px    += dx;
        py    -= dy;
        resid += step;
      end
    end
    px = (px * GainQ15) >>> GainFrac;
    py = (py * GainQ15) >>> GainFrac;
    res.x = OutW'(px);
    res.y = OutW'(py);
    return res;
  endfunction

  // Coordinates lean on the extremes now and then
  function automatic logic [DataWidth-1:0] pick_coord();
    logic [DataWidth-1:0] v;
    case ($urandom_range(0, 15))
      0:       v = {1'b1, {(DataWidth-1){1'b0}}};
      1:       v = {1'b0, {(DataWidth-1){1'b1}}};
      2:       v = '0;
      3:       v = '1;
      default: v = DataWidth'($urandom);
    endcase
    return v;
  endfunction

  // Angles lean on the fold boundaries now and then
  function automatic logic [AngleWidth-1:0] pick_angle();
    longint base;
    if ($urandom_range(0, 3) != 0) return AngleWidth'($urandom);
    base = AngQuarter * $urandom_range(0, 3);
    return AngleWidth'(base + $urandom_range(0, 4) - 2);
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one input transfer. Entered and left right after a rising edge;
  // tvalid stays high into the next call so back-to-back items need no gap.
  // --------------------------------------------------------------------------
  task automatic send_point(input logic [DataWidth-1:0]  x,
                            input logic [DataWidth-1:0]  y,
                            input logic [AngleWidth-1:0] ang);
    int unsigned         gap;
    logic [InTdataW-1:0] word;
    bit                  took;
    gap  = tx_idle_en ? $urandom_range(0, 9) : 0;
    word = '0;
    word[DataWidth-1:0]            = x;
    word[2*DataWidth-1:DataWidth]  = y;
    word[2*DataWidth +: AngleWidth] = ang;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    // ready is sampled mid-cycle, away from the edge where it may change
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    expected_rotations.push_back(rotate_point(x, y, ang));
  endtask

  // Stop offering and let every owed result come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_rotations.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: per result a random stall, or the long hold-off when asked.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    bit          took;
    forever begin
      if (hold_req) begin
        stall    = hold_cycles;
        hold_req = 1'b0;
      end else begin
        stall = rx_idle_en ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        took = rst_ni && m_axis_tvalid;
        @(posedge clk_i);
      end while (!took);
    end
  end

  // Result check: a transfer is certain once both sides are high mid-cycle
  always @(negedge clk_i) begin : result_check
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x = m_axis_tdata[OutW-1:0];
      got.y = m_axis_tdata[2*OutW-1:OutW];
      if (expected_rotations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: x=%0d y=%0d", got.x, got.y);
      end else begin
        want = expected_rotations.pop_front();
        if (got.x !== want.x || got.y !== want.y) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                     want.x, want.y, got.x, got.y);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corners: coordinate extremes, fold boundaries, half turn, angle wrap
  task automatic test_corners();
    logic [DataWidth-1:0]  x_min, x_max, zero, neg1;
    logic [AngleWidth-1:0] q1, q2, q3;
    x_min = {1'b1, {(DataWidth-1){1'b0}}};
    x_max = {1'b0, {(DataWidth-1){1'b1}}};
    zero  = '0;
    neg1  = '1;
    q1    = AngleWidth'(AngQuarter);
    q2    = AngleWidth'(AngHalf);
    q3    = AngleWidth'(3 * AngQuarter);
    send_point(zero,  zero,  '0);
    send_point(x_max, zero,  '0);
    send_point(x_min, x_min, '0);
    send_point(x_max, x_max, q1);        // quarter turn, not folded
    send_point(x_min, x_max, q3);        // minus quarter, not folded
    send_point(x_min, x_min, q1);
    send_point(x_max, x_min, q1 + 1'b1); // just past a quarter: folds
    send_point(x_min, x_max, q1 - 1'b1);
    send_point(x_min, zero,  q3 - 1'b1); // just past minus quarter: folds
    send_point(x_max, neg1,  q3 + 1'b1);
    send_point(x_min, x_min, q2);        // half turn: negates the point
    send_point(x_max, x_max, q2);
    send_point(x_min, zero,  q2);
    send_point(zero,  x_min, q2 - 1'b1);
    send_point(x_max, x_min, q2 + 1'b1);
    send_point(x_max, x_max, '1);        // angle just below a full turn
    send_point(x_min, x_min, AngleWidth'(1));
    send_point(x_max, x_max, q1 >> 1);   // 45 degrees: largest magnitude
    send_point(x_min, x_min, q1 >> 1);
    send_point(x_min, x_max, q3 + (q1 >> 1));
    send_point(neg1,  neg1,  q3);
    send_point(neg1,  AngleWidth'(1), q1);
    wait_drained();
  endtask

  // Random points; idling on each side switches on and off in stretches
  task automatic test_random_points(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_point(pick_coord(), pick_coord(), pick_angle());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Output held off for a long stretch while input keeps coming: the pipe
  // fills and must push back on the input without losing anything
  task automatic test_output_hold();
    tx_idle_en  = 1'b0;
    hold_cycles = 300;
    hold_req    = 1'b1;
    for (int n = 0; n < 80; n++) send_point(pick_coord(), pick_coord(), pick_angle());
    tx_idle_en  = 1'b1;
    wait_drained();
  endtask

  // Short bursts, each drained fully before the next
  task automatic test_drained_bursts();
    for (int b = 0; b < 5; b++) begin
      for (int n = 0; n < 8; n++) send_point(pick_coord(), pick_coord(), pick_angle());
      wait_drained();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corners();
    test_random_points(420);
    test_output_hold();
    test_drained_bursts();
    test_random_points(410);

    wait_drained();
    repeat (2 * PipeDepth) @(posedge clk_i);
    if (mismatch_count == 0 && expected_rotations.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
design/vrot_pkg.sv
design/vrot_micro.sv
design/vector_rotate_by_angle_unit.sv
bench/vector_rotate_by_angle_unit_tb.sv
